>>> hdl/rpwu_pkg.sv
// Shared types, widths and helpers for the iRprop+ weight update engine.
// Used by rpwu_front, rpwu_back and rprop_weight_update; no dependencies.
package rpwu_pkg;

	localparam int IDX_W       = 10;
	localparam int NUM_WEIGHTS = 2 ** IDX_W;
	localparam int WEIGHT_W    = 32;
	localparam int STEP_W      = 31;
	localparam int INC_W       = 16;
	localparam int DEC_W       = 9;
	localparam int MIN_W       = 17;
	localparam int FRAC_SH     = 8;
	localparam int PROD_W      = STEP_W + INC_W;
	localparam int SHIFTED_W   = PROD_W - FRAC_SH;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 31;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [STEP_W-1:0] STEP_CAP = '1;

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_LOAD   = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_INC  = 3'd0,
		REG_STEP_DEC  = 3'd1,
		REG_STEP_MAX  = 3'd2,
		REG_STEP_MIN  = 3'd3,
		REG_INIT_STEP = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [INC_W-1:0]  step_inc;
		logic [DEC_W-1:0]  step_dec;
		logic [STEP_W-1:0] step_max;
		logic [MIN_W-1:0]  step_min;
		logic [STEP_W-1:0] init_step;
	} rpwu_cfg_t;

	// One queued item: wrapped index and gradient sign already worked out.
	typedef struct packed {
		cmd_t                       cmd;
		logic [IDX_W-1:0]           idx;
		logic                       gpos;
		logic                       gneg;
		logic signed [WEIGHT_W-1:0] load_value;
		logic                       err_up;
	} rpwu_item_t;

	// One table entry; only the sign of the last gradient matters.
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic [STEP_W-1:0]          step;
		logic                       lg_pos;
		logic                       lg_neg;
		logic signed [WEIGHT_W-1:0] change;
	} rpwu_entry_t;

	localparam int ENTRY_W = $bits(rpwu_entry_t);

	function automatic logic signed [WEIGHT_W-1:0] sat_add(
		input logic signed [WEIGHT_W-1:0] a,
		input logic signed [WEIGHT_W-1:0] b
	);
		logic signed [WEIGHT_W:0] s;
		s = {a[WEIGHT_W-1], a} + {b[WEIGHT_W-1], b};
		if (s[WEIGHT_W] != s[WEIGHT_W-1])
			return s[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
		return s[WEIGHT_W-1:0];
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] sat_sub(
		input logic signed [WEIGHT_W-1:0] a,
		input logic signed [WEIGHT_W-1:0] b
	);
		logic signed [WEIGHT_W:0] s;
		s = {a[WEIGHT_W-1], a} - {b[WEIGHT_W-1], b};
		if (s[WEIGHT_W] != s[WEIGHT_W-1])
			return s[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
		return s[WEIGHT_W-1:0];
	endfunction

endpackage

>>> hdl/rpwu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpwu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/rpwu_front.sv
// Front end: takes input beats, wraps the index, classifies the gradient sign
// and queues the item for the back end. Depends on rpwu_pkg.
module rpwu_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [rpwu_pkg::IDX_W-1:0]         weight_index,
	input  logic signed [rpwu_pkg::WEIGHT_W-1:0] gradient,
	input  logic signed [rpwu_pkg::WEIGHT_W-1:0] load_value,
	input  logic                               error_increased,
	output logic                               q_valid,
	input  logic                               q_ready,
	output rpwu_pkg::rpwu_item_t               q_item
);
	import rpwu_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	rpwu_item_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	rpwu_item_t       item;
	logic             push;
	logic             pop;

	always_comb begin
		item.cmd        = cmd_t'(cmd);
		// The index port is exactly as wide as the table, so it wraps by itself.
		item.idx        = weight_index;
		item.load_value = load_value;
		item.err_up     = error_increased;
		// A load carries no gradient sign.
		item.gpos = (item.cmd == CMD_UPDATE) && !gradient[WEIGHT_W-1] && (|gradient);
		item.gneg = (item.cmd == CMD_UPDATE) && gradient[WEIGHT_W-1];
	end

	assign in_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= item;
	end

endmodule

>>> hdl/rpwu_back.sv
// Back end: reads the entry, scales and bounds the step, updates the weight,
// writes the entry back and holds the result. Depends on rpwu_pkg, rpwu_ram.
module rpwu_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rpwu_pkg::rpwu_cfg_t                  cfg,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  rpwu_pkg::rpwu_item_t                 q_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rpwu_pkg::IDX_W-1:0]           out_index,
	output logic signed [rpwu_pkg::WEIGHT_W-1:0] new_weight,
	output logic [rpwu_pkg::STEP_W-1:0]          new_step
);
	import rpwu_pkg::*;

	logic adv;
	logic hazard;
	logic issue;

	// stage 1: entry read data arrives
	logic             valid_s1;
	rpwu_item_t       item_s1;
	logic [ENTRY_W-1:0] rd_data;
	rpwu_entry_t      ent;
	logic             is_load;
	logic             same;
	logic             flip;
	logic [INC_W-1:0] factor;
	logic [PROD_W-1:0] prod;

	// stage 2: product registered
	logic                       valid_s2;
	logic [IDX_W-1:0]           idx_s2;
	logic                       load_s2;
	logic                       same_s2;
	logic                       flip_s2;
	logic                       err_s2;
	logic                       gpos_s2;
	logic                       gneg_s2;
	logic [PROD_W-1:0]          prod_s2;
	logic signed [WEIGHT_W-1:0] weight_s2;
	logic [STEP_W-1:0]          step_s2;
	logic signed [WEIGHT_W-1:0] change_s2;
	logic [SHIFTED_W-1:0]       shifted;
	logic [STEP_W-1:0]          scaled;
	logic [STEP_W-1:0]          min_ext;
	logic [STEP_W-1:0]          step_next;
	logic signed [WEIGHT_W-1:0] weight_next;

	// stage 3: step settled, weight sum and write-back
	logic                       valid_s3;
	logic [IDX_W-1:0]           idx_s3;
	logic                       load_s3;
	logic                       flip_s3;
	logic                       gpos_s3;
	logic                       gneg_s3;
	logic signed [WEIGHT_W-1:0] weight_s3;
	logic [STEP_W-1:0]          step_s3;
	logic signed [WEIGHT_W-1:0] change_s3;
	logic signed [WEIGHT_W-1:0] step_signed;
	logic signed [WEIGHT_W-1:0] delta;
	rpwu_entry_t                wr_ent;

	// result register
	logic                       out_valid_q;
	logic [IDX_W-1:0]           out_index_q;
	logic signed [WEIGHT_W-1:0] new_weight_q;
	logic [STEP_W-1:0]          new_step_q;

	// The whole back pipeline moves together; stall it when the result is held.
	assign adv = !out_valid_q || out_ready;

	// Hold the head while an older item to the same entry has not been written.
	assign hazard = (valid_s1 && (item_s1.idx == q_item.idx)) ||
	                (valid_s2 && (idx_s2 == q_item.idx)) ||
	                (valid_s3 && (idx_s3 == q_item.idx));
	assign issue   = adv && q_valid && !hazard;
	assign q_ready = issue;

	rpwu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_WEIGHTS)
	) u_table (
		.clk   (clk),
		.we    (adv && valid_s3),
		.waddr (idx_s3),
		.wdata (wr_ent),
		.re    (issue),
		.raddr (q_item.idx),
		.rdata (rd_data)
	);

	always_comb begin
		ent     = rpwu_entry_t'(rd_data);
		is_load = (item_s1.cmd == CMD_LOAD);
		same    = !is_load && ((item_s1.gpos && ent.lg_pos) || (item_s1.gneg && ent.lg_neg));
		flip    = !is_load && ((item_s1.gpos && ent.lg_neg) || (item_s1.gneg && ent.lg_pos));
		factor  = flip ? {{(INC_W-DEC_W){1'b0}}, cfg.step_dec} : cfg.step_inc;
		prod    = ent.step * factor;
	end

	always_comb begin
		shifted = prod_s2[PROD_W-1:FRAC_SH];
		scaled  = (|shifted[SHIFTED_W-1:STEP_W]) ? STEP_CAP : shifted[STEP_W-1:0];
		min_ext = {{(STEP_W-MIN_W){1'b0}}, cfg.step_min};
		step_next = step_s2;
		if (same_s2)
			step_next = (scaled > cfg.step_max) ? cfg.step_max : scaled;
		else if (flip_s2)
			step_next = (scaled < min_ext) ? min_ext : scaled;
		// Undo the last change when the error rose after a sign flip.
		weight_next = (flip_s2 && err_s2) ? sat_sub(weight_s2, change_s2) : weight_s2;
	end

	always_comb begin
		step_signed = {1'b0, step_s3};
		if (gpos_s3)
			delta = -step_signed;
		else if (gneg_s3)
			delta = step_signed;
		else
			delta = '0;
		if (load_s3) begin
			wr_ent.weight = weight_s3;
			wr_ent.step   = step_s3;
			wr_ent.lg_pos = 1'b0;
			wr_ent.lg_neg = 1'b0;
			wr_ent.change = '0;
		end else if (flip_s3) begin
			wr_ent.weight = weight_s3;
			wr_ent.step   = step_s3;
			wr_ent.lg_pos = 1'b0;
			wr_ent.lg_neg = 1'b0;
			wr_ent.change = change_s3;
		end else begin
			wr_ent.weight = sat_add(weight_s3, delta);
			wr_ent.step   = step_s3;
			wr_ent.lg_pos = gpos_s3;
			wr_ent.lg_neg = gneg_s3;
			wr_ent.change = delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_item;

			idx_s2    <= item_s1.idx;
			load_s2   <= is_load;
			same_s2   <= same;
			flip_s2   <= flip;
			err_s2    <= item_s1.err_up;
			gpos_s2   <= item_s1.gpos;
			gneg_s2   <= item_s1.gneg;
			prod_s2   <= prod;
			weight_s2 <= is_load ? item_s1.load_value : ent.weight;
			step_s2   <= is_load ? cfg.init_step : ent.step;
			change_s2 <= ent.change;

			idx_s3    <= idx_s2;
			load_s3   <= load_s2;
			flip_s3   <= flip_s2;
			gpos_s3   <= gpos_s2;
			gneg_s3   <= gneg_s2;
			weight_s3 <= weight_next;
			step_s3   <= step_next;
			change_s3 <= change_s2;

			out_index_q  <= idx_s3;
			new_weight_q <= wr_ent.weight;
			new_step_q   <= wr_ent.step;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign new_weight = new_weight_q;
	assign new_step   = new_step_q;

endmodule

>>> hdl/rprop_weight_update.sv
// Top level of the iRprop+ weight update engine: configuration registers,
// front end and back end. Depends on rpwu_pkg, rpwu_front, rpwu_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one beat per item: cmd selects a
//   load (write weight, set initial step, clear training state) or an update
//   (one iRprop+ step driven by the gradient sign). Each item gives exactly
//   one result beat on out_valid/out_ready, in order.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no item is in flight.
//   From the accepting edge to out_valid an item passes, with no stall, queue
//   pop with table read, step scaling, step bound and weight sum.
//   Throughput is one item per cycle while no held result stalls the back end
//   and no item addresses an entry still in the three back stages; such an
//   item waits until that entry is written back.
//   A four-entry queue lets input beats keep coming while the back end is
//   held by a stalled receiver; the result register holds its beat until taken.
//   Reset restores the register defaults and empties queue and pipeline; the
//   weight table is not cleared and an entry must be loaded before update.
module rprop_weight_update (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rpwu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rpwu_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   cmd,
	input  logic [rpwu_pkg::IDX_W-1:0]             weight_index,
	input  logic signed [rpwu_pkg::WEIGHT_W-1:0]   gradient,
	input  logic signed [rpwu_pkg::WEIGHT_W-1:0]   load_value,
	input  logic                                   error_increased,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [rpwu_pkg::IDX_W-1:0]             out_index,
	output logic signed [rpwu_pkg::WEIGHT_W-1:0]   new_weight,
	output logic [rpwu_pkg::STEP_W-1:0]            new_step
);
	import rpwu_pkg::*;

	rpwu_cfg_t  cfg_q;
	logic       q_valid;
	logic       q_ready;
	rpwu_item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_inc  <= INC_W'(307);
			cfg_q.step_dec  <= DEC_W'(128);
			cfg_q.step_max  <= STEP_W'(3276800);
			cfg_q.step_min  <= MIN_W'(1);
			cfg_q.init_step <= STEP_W'(6554);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_INC:  cfg_q.step_inc  <= cfg_data[INC_W-1:0];
				REG_STEP_DEC:  cfg_q.step_dec  <= cfg_data[DEC_W-1:0];
				REG_STEP_MAX:  cfg_q.step_max  <= cfg_data[STEP_W-1:0];
				REG_STEP_MIN:  cfg_q.step_min  <= cfg_data[MIN_W-1:0];
				REG_INIT_STEP: cfg_q.init_step <= cfg_data[STEP_W-1:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	rpwu_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.weight_index    (weight_index),
		.gradient        (gradient),
		.load_value      (load_value),
		.error_increased (error_increased),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.q_item          (q_item)
	);

	rpwu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_index  (out_index),
		.new_weight (new_weight),
		.new_step   (new_step)
	);

	// A head item held back by the back end must not change under it.
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_ready |=> q_valid && (q_item == $past(q_item)))
		else $error("queue head changed while held");

	// The back end never pops an empty queue.
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> q_valid)
		else $error("pop from empty queue");

	// Loads reach the back end with no gradient sign.
	a_load_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && (q_item.cmd == CMD_LOAD) |-> !q_item.gpos && !q_item.gneg)
		else $error("load item carries a gradient sign");

endmodule
